// ===== rtl/jlfe_pkg.sv =====
// jlfe_pkg: shared types and constants of the json line field extractor
// holds parse phase, status, kind and register codes, character constants, the queue item type
// no dependencies
package jlfe_pkg;

  // parse phases
  localparam logic [2:0] PH_SEARCH    = 3'd0;
  localparam logic [2:0] PH_PRE_COLON = 3'd1;
  localparam logic [2:0] PH_PRE_VALUE = 3'd2;
  localparam logic [2:0] PH_IN_STRING = 3'd3;
  localparam logic [2:0] PH_IN_BARE   = 3'd4;
  localparam logic [2:0] PH_DONE      = 3'd5;

  // line status codes
  localparam logic [1:0] ST_FOUND        = 2'd0;
  localparam logic [1:0] ST_ABSENT       = 2'd1;
  localparam logic [1:0] ST_MALFORMED    = 2'd2;
  localparam logic [1:0] ST_UNTERMINATED = 2'd3;

  // input and result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOL  = 1'b1;
  localparam logic RES_VALUE  = 1'b0;
  localparam logic RES_STATUS = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_LENGTH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW    = 2'd1;
  localparam logic [1:0] REG_KEY_HIGH   = 2'd2;
  localparam logic [1:0] REG_MODE       = 2'd3;

  // characters
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam int KEY_CHARS = 16;
  localparam int QDEPTH    = 2;

  typedef logic [KEY_CHARS-1:0][7:0] key_bytes_t;

  // one classified beat handed from front to back
  typedef struct packed {
    logic       eol;
    logic [7:0] data;
    logic       blank;
    logic       colon;
    logic       quote;
    logic       bslash;
    logic       bad_lead;  // comma, brace, cr or lf
    logic       zero;
    logic       hit;       // closing quote of the key needle
  } item_t;

endpackage

// ===== rtl/jlfe_front.sv =====
// jlfe_front: accepts line beats, keeps the recent byte window and classifies each beat
// depends on jlfe_pkg
module jlfe_front #(
  parameter int KEY_MAX = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic                in_kind,
  input  logic [7:0]          in_byte,
  input  logic [4:0]          key_length,
  input  jlfe_pkg::key_bytes_t key_bytes,
  output jlfe_pkg::item_t     item
);

  localparam int CW = $clog2(KEY_MAX + 2);
  localparam logic [4:0] KMAX5 = 5'(KEY_MAX);

  logic [KEY_MAX:0][7:0] win_r;
  logic [CW-1:0]         cnt_r;
  logic [4:0]            len_c;
  logic [KEY_MAX:0]      pos_ok;
  logic [4:0]            idx [KEY_MAX:0];
  logic                  is_eol;

  assign is_eol = (in_kind == jlfe_pkg::KIND_EOL);
  assign len_c  = (key_length > KMAX5) ? KMAX5 : key_length;

  // compare the window against quote, key, at the variable key length
  always_comb begin
    for (int k = 0; k <= KEY_MAX; k++) begin
      idx[k] = len_c - 5'(k) - 5'd1;
      if (5'(k) < len_c) begin
        pos_ok[k] = (win_r[k] == key_bytes[idx[k][3:0]]);
      end else if (5'(k) == len_c) begin
        pos_ok[k] = (win_r[k] == jlfe_pkg::CH_QUOTE);
      end else begin
        pos_ok[k] = 1'b1;
      end
    end
  end

  always_comb begin
    item.eol      = is_eol;
    item.data     = in_byte;
    item.blank    = (in_byte == jlfe_pkg::CH_SPACE) || (in_byte == jlfe_pkg::CH_TAB);
    item.colon    = (in_byte == jlfe_pkg::CH_COLON);
    item.quote    = (in_byte == jlfe_pkg::CH_QUOTE);
    item.bslash   = (in_byte == jlfe_pkg::CH_BSLASH);
    item.bad_lead = (in_byte == jlfe_pkg::CH_COMMA) || (in_byte == jlfe_pkg::CH_RBRACE) ||
                    (in_byte == jlfe_pkg::CH_LF) || (in_byte == jlfe_pkg::CH_CR);
    item.zero     = (in_byte == jlfe_pkg::CH_NUL);
    item.hit      = item.quote && ({1'b0, 5'(cnt_r)} >= ({1'b0, len_c} + 6'd1)) && (&pos_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      cnt_r <= '0;
    end else if (push) begin
      if (is_eol) begin
        win_r <= '0;
        cnt_r <= '0;
      end else begin
        win_r <= {win_r[KEY_MAX-1:0], in_byte};
        if (cnt_r < CW'(KEY_MAX + 1)) begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/jlfe_queue.sv =====
// jlfe_queue: two entry queue of classified beats between front and back
// depends on jlfe_pkg
module jlfe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jlfe_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output jlfe_pkg::item_t head
);

  localparam int PW = $clog2(jlfe_pkg::QDEPTH);

  jlfe_pkg::item_t mem_r [jlfe_pkg::QDEPTH];
  logic [PW-1:0]   wr_r;
  logic [PW-1:0]   rd_r;
  logic [PW:0]     cnt_r;

  assign full      = (cnt_r == (PW+1)'(jlfe_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/jlfe_back.sv =====
// jlfe_back: parse state machine that turns classified beats into value bytes and status
// depends on jlfe_pkg; holds the registered result stage
module jlfe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            extract_mode,
  input  logic            q_not_empty,
  input  jlfe_pkg::item_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_kind,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_status
);

  logic [2:0] phase_r, phase_nxt;
  logic       esc_r, esc_nxt;
  logic       nonempty_r, nonempty_nxt;
  logic [1:0] lstat_r, lstat_nxt;
  logic       valid_r;
  logic       kind_r;
  logic [7:0] byte_r;
  logic [1:0] status_r;
  logic       emit, emit_status;
  logic [1:0] end_st;

  assign pop = q_not_empty && (!valid_r || out_ready);

  // outcome if the line ended now
  always_comb begin
    case (phase_r)
      jlfe_pkg::PH_SEARCH:    end_st = jlfe_pkg::ST_ABSENT;
      jlfe_pkg::PH_PRE_COLON: end_st = jlfe_pkg::ST_MALFORMED;
      jlfe_pkg::PH_PRE_VALUE: end_st = jlfe_pkg::ST_MALFORMED;
      jlfe_pkg::PH_IN_STRING: end_st = jlfe_pkg::ST_UNTERMINATED;
      jlfe_pkg::PH_IN_BARE:
        end_st = nonempty_r ? jlfe_pkg::ST_FOUND : jlfe_pkg::ST_MALFORMED;
      default:                end_st = lstat_r;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    esc_nxt      = esc_r;
    nonempty_nxt = nonempty_r;
    lstat_nxt    = lstat_r;
    emit         = 1'b0;
    emit_status  = 1'b0;
    if (pop) begin
      if (head.eol) begin
        emit_status  = 1'b1;
        phase_nxt    = jlfe_pkg::PH_SEARCH;
        esc_nxt      = 1'b0;
        nonempty_nxt = 1'b0;
        lstat_nxt    = jlfe_pkg::ST_ABSENT;
      end else if (phase_r == jlfe_pkg::PH_DONE) begin
        phase_nxt = phase_r;
      end else if (head.zero) begin
        lstat_nxt = end_st;
        phase_nxt = jlfe_pkg::PH_DONE;
      end else begin
        case (phase_r)
          jlfe_pkg::PH_SEARCH: begin
            if (head.hit) begin
              phase_nxt = jlfe_pkg::PH_PRE_COLON;
            end
          end
          jlfe_pkg::PH_PRE_COLON: begin
            if (!head.blank) begin
              if (head.colon) begin
                phase_nxt = jlfe_pkg::PH_PRE_VALUE;
              end else begin
                lstat_nxt = jlfe_pkg::ST_MALFORMED;
                phase_nxt = jlfe_pkg::PH_DONE;
              end
            end
          end
          jlfe_pkg::PH_PRE_VALUE: begin
            if (!head.blank) begin
              if (head.quote) begin
                phase_nxt = jlfe_pkg::PH_IN_STRING;
              end else if (!extract_mode || head.bad_lead) begin
                lstat_nxt = jlfe_pkg::ST_MALFORMED;
                phase_nxt = jlfe_pkg::PH_DONE;
              end else begin
                phase_nxt = jlfe_pkg::PH_IN_BARE;
                emit      = 1'b1;
              end
            end
          end
          jlfe_pkg::PH_IN_STRING: begin
            if (esc_r) begin
              esc_nxt = 1'b0;
              emit    = 1'b1;
            end else if (head.bslash) begin
              esc_nxt = 1'b1;
            end else if (head.quote) begin
              lstat_nxt = jlfe_pkg::ST_FOUND;
              phase_nxt = jlfe_pkg::PH_DONE;
            end else begin
              emit = 1'b1;
            end
          end
          default: begin
            if (head.blank || head.bad_lead) begin
              lstat_nxt = jlfe_pkg::ST_FOUND;
              phase_nxt = jlfe_pkg::PH_DONE;
            end else begin
              emit = 1'b1;
            end
          end
        endcase
        if (emit) begin
          nonempty_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= jlfe_pkg::PH_SEARCH;
      esc_r      <= 1'b0;
      nonempty_r <= 1'b0;
      lstat_r    <= jlfe_pkg::ST_ABSENT;
      valid_r    <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      esc_r      <= esc_nxt;
      nonempty_r <= nonempty_nxt;
      lstat_r    <= lstat_nxt;
      if (emit || emit_status) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit || emit_status) begin
      kind_r   <= emit_status ? jlfe_pkg::RES_STATUS : jlfe_pkg::RES_VALUE;
      byte_r   <= emit_status ? 8'd0 : head.data;
      status_r <= emit_status ? end_st : jlfe_pkg::ST_FOUND;
    end
  end

  assign out_valid  = valid_r;
  assign out_kind   = kind_r;
  assign out_byte   = byte_r;
  assign out_status = status_r;

endmodule

// ===== rtl/json_line_field_extractor.sv =====
// json_line_field_extractor: pulls the value of one configured key out of a json line
// path: a taken line beat is written into the queue, popped by the back end, and its result is registered
// throughput: one line beat per cycle while out_tready holds, set by the parse step in the back end
// the front end keeps taking beats into a two entry queue while a result waits, until the queue is full
// reset: synchronous active low, config to reset values, line state cleared, no sweep
// depends on jlfe_pkg, jlfe_front, jlfe_queue, jlfe_back
module json_line_field_extractor #(
  parameter int KEY_MAX = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // line input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] line_byte
  input  logic        in_tuser,   // [0] kind
  // result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] value_byte, [9:8] status, rest zero
  output logic        out_tlast,  // result_kind: high on the line status beat
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [4:0]  key_len_r;
  logic [63:0] key_lo_r;
  logic [63:0] key_hi_r;
  logic        mode_r;
  logic [1:0]  reg_sel;
  logic        cfg_wr;

  jlfe_pkg::key_bytes_t key_bytes;
  jlfe_pkg::item_t      front_item;
  jlfe_pkg::item_t      q_head;

  logic       q_full;
  logic       q_not_empty;
  logic       push;
  logic       pop;
  logic       res_kind;
  logic [7:0] res_byte;
  logic [1:0] res_status;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[4:3];   // 8 byte register spacing
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      mode_r    <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_sel)
        jlfe_pkg::REG_KEY_LENGTH: key_len_r <= cfg_pwdata[4:0];
        jlfe_pkg::REG_KEY_LOW:    key_lo_r  <= cfg_pwdata;
        jlfe_pkg::REG_KEY_HIGH:   key_hi_r  <= cfg_pwdata;
        default:                  mode_r    <= cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      jlfe_pkg::REG_KEY_LENGTH: cfg_prdata = {59'd0, key_len_r};
      jlfe_pkg::REG_KEY_LOW:    cfg_prdata = key_lo_r;
      jlfe_pkg::REG_KEY_HIGH:   cfg_prdata = key_hi_r;
      default:                  cfg_prdata = {63'd0, mode_r};
    endcase
  end

  // key character i sits at byte i of the concatenated key registers
  assign key_bytes = {key_hi_r, key_lo_r};

  // front end takes a beat whenever the queue has room
  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  jlfe_front #(
    .KEY_MAX (KEY_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_kind    (in_tuser),
    .in_byte    (in_tdata),
    .key_length (key_len_r),
    .key_bytes  (key_bytes),
    .item       (front_item)
  );

  jlfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back end pops a beat whenever the result register is free or draining
  jlfe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .extract_mode (mode_r),
    .q_not_empty  (q_not_empty),
    .head         (q_head),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (res_kind),
    .out_byte     (res_byte),
    .out_status   (res_status)
  );

  assign out_tdata = {6'd0, res_status, res_byte};
  assign out_tlast = res_kind;

endmodule
